FILE: hdl/cia_pkg.sv
// Package: shared types, constants and status codes for the complex integer ALU.
package cia_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned QuoW  = 32;
    localparam logic signed [DataW-1:0] INT_MIN = {1'b1, {(DataW-1){1'b0}}};

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [DataW-1:0] a_real;
        logic signed [DataW-1:0] a_imag;
        logic signed [DataW-1:0] b_real;
        logic signed [DataW-1:0] b_imag;
    } t_cia_in;

    typedef struct packed {
        logic signed [DataW-1:0] res_real;
        logic signed [DataW-1:0] res_imag;
        logic [1:0]              status;
    } t_cia_out;

    // True when a 64-bit signed value fits in 32 bits
    function automatic logic fits32(input logic signed [63:0] v);
        return (v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}});
    endfunction
endpackage

FILE: hdl/cia_if.sv
// Interfaces: valid/ready channels for operand and result transfers.
interface cia_in_if
    import cia_pkg::*;
();
    logic    valid;
    logic    ready;
    t_cia_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cia_out_if
    import cia_pkg::*;
();
    logic     valid;
    logic     ready;
    t_cia_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/cia_front.sv
// Front stages: products, sums and error classification, two register stages.
module cia_front
    import cia_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_cia_in                 i_data,
    output logic                    o_valid,
    output logic                    o_div,
    output logic [1:0]              o_status,
    output logic signed [DataW-1:0] o_re,
    output logic signed [DataW-1:0] o_im,
    output logic signed [DataW-1:0] o_den
);
    // stage 1 registers: six products, add/sub sums
    logic                    r_v1;
    logic [1:0]              r_op1;
    logic                    r_dz1;
    logic signed [63:0]      r_ac, r_bd, r_ad, r_bc, r_cc, r_dd;
    logic signed [63:0]      r_s_re, r_s_im;
    logic signed [63:0]      n_s_re, n_s_im;
    logic signed [63:0]      a, b, c, d;

    assign a = 64'(i_data.a_real);
    assign b = 64'(i_data.a_imag);
    assign c = 64'(i_data.b_real);
    assign d = 64'(i_data.b_imag);

    always_comb begin
        if (i_data.op == OP_ADD) begin
            n_s_re = a + c;
            n_s_im = b + d;
        end else begin
            n_s_re = a - c;
            n_s_im = b - d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_op1  <= i_data.op;
            r_dz1  <= (i_data.b_real == '0) && (i_data.b_imag == '0);
            r_ac   <= a * c;
            r_bd   <= b * d;
            r_ad   <= a * d;
            r_bc   <= b * c;
            r_cc   <= c * c;
            r_dd   <= d * d;
            r_s_re <= n_s_re;
            r_s_im <= n_s_im;
        end
    end

    // stage 2: classify and combine
    logic              prod_ok4, prod_ok6;
    logic signed [63:0] nr, den, ni;
    logic [1:0]        n_st;
    logic signed [DataW-1:0] n_re, n_im;

    always_comb begin
        prod_ok4 = fits32(r_ac) && fits32(r_bd) && fits32(r_ad) && fits32(r_bc);
        prod_ok6 = prod_ok4 && fits32(r_cc) && fits32(r_dd);
        nr  = r_ac + r_bd;
        den = r_cc + r_dd;
        ni  = r_bc - r_ad;
        n_st = ST_OK;
        n_re = '0;
        n_im = '0;
        unique case (r_op1)
            OP_ADD, OP_SUB: begin
                if (!fits32(r_s_re) || !fits32(r_s_im)) n_st = ST_OVF;
                n_re = r_s_re[DataW-1:0];
                n_im = r_s_im[DataW-1:0];
            end
            OP_MUL: begin
                if (!prod_ok4) n_st = ST_OVF;
                n_re = r_ac[DataW-1:0] - r_bd[DataW-1:0];
                n_im = r_ad[DataW-1:0] + r_bc[DataW-1:0];
            end
            default: begin
                if (r_dz1) n_st = ST_DIVZ;
                else if (!prod_ok6 || !fits32(nr) || !fits32(den) || !fits32(ni)
                         || den <= 0) n_st = ST_OVF;
                n_re = nr[DataW-1:0];
                n_im = ni[DataW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
        if (i_en) begin
            o_div    <= (r_op1 == OP_DIV);
            o_status <= n_st;
            o_re     <= n_re;
            o_im     <= n_im;
            o_den    <= den[DataW-1:0];
        end
    end
endmodule

FILE: hdl/cia_div.sv
// Pipelined divider: one restoring quotient bit per stage, both quotients in lockstep.
module cia_div
    import cia_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_div,
    input  logic [1:0]              i_status,
    input  logic signed [DataW-1:0] i_re,
    input  logic signed [DataW-1:0] i_im,
    input  logic signed [DataW-1:0] i_den,
    output logic                    o_valid,
    output t_cia_out                o_data
);
    localparam int unsigned N = QuoW;

    // per-stage state; magnitudes shift left into quotients
    logic             r_v   [N+1];
    logic             r_dv  [N+1];
    logic [1:0]       r_st  [N+1];
    logic             r_nr  [N+1];
    logic             r_ni  [N+1];
    logic [DataW-1:0] r_den [N+1];
    logic [DataW-1:0] r_rr  [N+1];
    logic [DataW-1:0] r_ri  [N+1];
    logic [DataW-1:0] r_qr  [N+1];
    logic [DataW-1:0] r_qi  [N+1];

    // entry stage: take magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_dv[0]  <= i_div;
            r_st[0]  <= i_status;
            r_nr[0]  <= i_re[DataW-1];
            r_ni[0]  <= i_im[DataW-1];
            r_den[0] <= i_den;
            r_rr[0]  <= '0;
            r_ri[0]  <= '0;
            r_qr[0]  <= (i_div && i_re[DataW-1]) ? DataW'(-i_re) : i_re;
            r_qi[0]  <= (i_div && i_im[DataW-1]) ? DataW'(-i_im) : i_im;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [DataW:0] tr, ti;
        always_comb begin
            tr = {r_rr[k], r_qr[k][DataW-1]} - {1'b0, r_den[k]};
            ti = {r_ri[k], r_qi[k][DataW-1]} - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_dv[k+1]  <= r_dv[k];
                r_st[k+1]  <= r_st[k];
                r_nr[k+1]  <= r_nr[k];
                r_ni[k+1]  <= r_ni[k];
                r_den[k+1] <= r_den[k];
                if (r_dv[k]) begin
                    r_rr[k+1] <= tr[DataW] ? {r_rr[k][DataW-2:0], r_qr[k][DataW-1]}
                                           : tr[DataW-1:0];
                    r_ri[k+1] <= ti[DataW] ? {r_ri[k][DataW-2:0], r_qi[k][DataW-1]}
                                           : ti[DataW-1:0];
                    r_qr[k+1] <= {r_qr[k][DataW-2:0], ~tr[DataW]};
                    r_qi[k+1] <= {r_qi[k][DataW-2:0], ~ti[DataW]};
                end else begin
                    r_rr[k+1] <= r_rr[k];
                    r_ri[k+1] <= r_ri[k];
                    r_qr[k+1] <= r_qr[k];
                    r_qi[k+1] <= r_qi[k];
                end
            end
        end
    end

    // output: sign fix and zero on error
    always_comb begin
        o_valid = r_v[N];
        o_data.status = r_st[N];
        if (r_st[N] != ST_OK) begin
            o_data.res_real = '0;
            o_data.res_imag = '0;
        end else if (r_dv[N]) begin
            o_data.res_real = r_nr[N] ? DataW'(-r_qr[N]) : r_qr[N];
            o_data.res_imag = r_ni[N] ? DataW'(-r_qi[N]) : r_qi[N];
        end else begin
            o_data.res_real = r_qr[N];
            o_data.res_imag = r_qi[N];
        end
    end
endmodule

FILE: hdl/complex_int_alu_with_overflow_top.sv
// Top level: complex integer ALU with overflow and divide-by-zero status.
//
// Channels: i_op_ch carries op and four 32-bit signed components; o_res_ch
// returns real and imaginary parts plus a status (ok, overflow, divide by
// zero). Every transfer in gives exactly one transfer out, in order.
// Results on error are zero.
// Path from input transfer to result valid: two stages of products and
// classification, one entry stage, one stage per quotient bit of the 32-step
// restoring divider that all ops pass through, then one output register.
// Throughput: one item per cycle when not stalled; the divider pipeline is the deepest path.
// Reset clears all valid bits; payload registers are not reset.
// Stall: the whole pipeline advances when the output register is empty or
// being taken; when it is full and the receiver holds ready low the
// pipeline freezes and the input ready drops, losing and repeating nothing.
module complex_int_alu_with_overflow_top
    import cia_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cia_in_if.sink   i_op_ch,
    cia_out_if.source o_res_ch
);
    logic                    en;
    logic                    f_valid, f_div;
    logic [1:0]              f_status;
    logic signed [DataW-1:0] f_re, f_im, f_den;
    logic                    d_valid;
    t_cia_out                d_data;
    logic                    r_ov;
    t_cia_out                r_od;

    assign en = !r_ov || o_res_ch.ready;
    assign i_op_ch.ready = en;

    cia_front u_front (
        .i_clk, .i_rst_n, .i_en(en),
        .i_valid(i_op_ch.valid), .i_data(i_op_ch.data),
        .o_valid(f_valid), .o_div(f_div), .o_status(f_status),
        .o_re(f_re), .o_im(f_im), .o_den(f_den)
    );

    cia_div u_div (
        .i_clk, .i_rst_n, .i_en(en),
        .i_valid(f_valid), .i_div(f_div), .i_status(f_status),
        .i_re(f_re), .i_im(f_im), .i_den(f_den),
        .o_valid(d_valid), .o_data(d_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= d_valid;
        end
        if (en) r_od <= d_data;
    end

    assign o_res_ch.valid = r_ov;
    assign o_res_ch.data  = r_od;
endmodule

FILE: dv/tb_complex_int_alu_with_overflow_top.sv
// Testbench: directed table and random operand transfers checked against a complex ALU predictor.
`timescale 1ns / 100ps

module tb_complex_int_alu_with_overflow_top;
    import cia_pkg::*;

    localparam int NumRandom   = 1450;
    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 60;

    logic i_clk;
    logic i_rst_n;
    cia_in_if  op_ch ();
    cia_out_if res_ch ();

    complex_int_alu_with_overflow_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op_ch  (op_ch.sink),
        .o_res_ch (res_ch.source)
    );

    // Directed row: operands plus optional typed-in answer
    typedef struct {
        t_cia_in  op_item;
        bit       has_fixed;
        t_cia_out fixed;
    } t_row;

    t_cia_out expected_results[$];
    int       n_errors;
    int       cycle_cnt;
    bit       stim_done;
    t_row     rows[$];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Cycle limit watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("complex_int_alu_with_overflow_top test failed");
            $finish;
        end
    end

    function automatic logic fits_s32(input logic signed [63:0] v);
        return v >= -64'sd2147483648 && v <= 64'sd2147483647;
    endfunction

    // Compute the complex result and status for one operand transfer
    function automatic t_cia_out compute_complex(input t_cia_in x);
        t_cia_out r;
        logic signed [63:0] a, b, c, d, re, im, ac, bd, ad, bc, cc, dd, nr, den, ni;
        logic [31:0] wr, wi;
        a  = x.a_real;
        b  = x.a_imag;
        c  = x.b_real;
        d  = x.b_imag;
        re = 0;
        im = 0;
        r.status = ST_OK;
        ac = a * c;
        bd = b * d;
        ad = a * d;
        bc = b * c;
        cc = c * c;
        dd = d * d;
        case (x.op)
            OP_ADD: begin
                re = a + c;
                im = b + d;
                if (!fits_s32(re) || !fits_s32(im)) r.status = ST_OVF;
            end
            OP_SUB: begin
                re = a - c;
                im = b - d;
                if (!fits_s32(re) || !fits_s32(im)) r.status = ST_OVF;
            end
            OP_MUL: begin
                if (!fits_s32(ac) || !fits_s32(bd) || !fits_s32(ad) || !fits_s32(bc)) begin
                    r.status = ST_OVF;
                end else begin
                    // combining sums wrap
                    wr = ac[31:0] - bd[31:0];
                    wi = ad[31:0] + bc[31:0];
                    re = {{32{wr[31]}}, wr};
                    im = {{32{wi[31]}}, wi};
                end
            end
            default: begin
                if (c == 0 && d == 0) begin
                    r.status = ST_DIVZ;
                end else if (!fits_s32(ac) || !fits_s32(bd) || !fits_s32(cc) ||
                             !fits_s32(dd) || !fits_s32(bc) || !fits_s32(ad)) begin
                    r.status = ST_OVF;
                end else begin
                    nr  = ac + bd;
                    den = cc + dd;
                    ni  = bc - ad;
                    if (!fits_s32(nr) || !fits_s32(den) || !fits_s32(ni) || den <= 0) begin
                        r.status = ST_OVF;
                    end else begin
                        re = nr / den;
                        im = ni / den;
                    end
                end
            end
        endcase
        if (r.status != ST_OK) begin
            re = 0;
            im = 0;
        end
        r.res_real = re[31:0];
        r.res_imag = im[31:0];
        return r;
    endfunction

    // Operand component: mostly small, some extremes, some full range
    function automatic logic [31:0] pick_component(input int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? INT_MIN :
                      $urandom_range(0, 2) == 0 ? 32'h7fff_ffff :
                      $urandom_range(0, 1) == 0 ? 32'hffff_ffff : 32'h0;
            2: return 32'($signed($urandom_range(0, 60000)) - 30000);
            default: return 32'($signed($urandom_range(0, 60)) - 30);
        endcase
    endfunction

    function automatic t_row make_row(input logic [1:0] op, input logic [31:0] ar,
                                      input logic [31:0] ai, input logic [31:0] br,
                                      input logic [31:0] bi, input bit has_fixed,
                                      input logic [31:0] rr, input logic [31:0] ri,
                                      input logic [1:0] st);
        t_row r;
        r.op_item   = '{op, ar, ai, br, bi};
        r.has_fixed = has_fixed;
        r.fixed     = '{rr, ri, st};
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input t_row r);
        rows.insert(rows.size(), r);
    endfunction

    // Wait a random gap: mostly none or short, sometimes long
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 9);
        if (n < 5) n = 0;
        else if (n < 9) n = $urandom_range(1, 3);
        else n = $urandom_range(5, 40);
        if (n > 0) op_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drive one operand transfer and record what it should return
    task automatic send_item(input t_cia_in x, input bit has_fixed, input t_cia_out fixed);
        t_cia_out pred;
        pred = compute_complex(x);
        if (has_fixed && pred != fixed)
            $error("table row disagrees with predictor: op=%0d", x.op);
        op_ch.valid <= 1'b1;
        op_ch.data  <= x;
        @(posedge i_clk);
        while (!op_ch.ready) @(posedge i_clk);
        expected_results.insert(expected_results.size(), has_fixed ? fixed : pred);
    endtask

    // Stimulus
    initial begin
        t_cia_in x;
        t_cia_out none;
        int mode;
        none = '0;
        n_errors  = 0;
        cycle_cnt = 0;
        stim_done = 1'b0;
        op_ch.valid  <= 1'b0;
        op_ch.data   <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero operands, extremes, every op, zero divisor, wrap cases
        add_row(make_row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, ST_OK));
        add_row(make_row(OP_ADD, 32'h7fffffff, 0, 1, 0, 1, 0, 0, ST_OVF));
        add_row(make_row(OP_ADD, 0, 32'h80000000, 0, 32'hffffffff, 1, 0, 0, ST_OVF));
        add_row(make_row(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 1, 32'hffffffff, 32'hffffffff, ST_OK));
        add_row(make_row(OP_SUB, 32'h80000000, 0, 1, 0, 1, 0, 0, ST_OVF));
        add_row(make_row(OP_SUB, 0, 0, 32'h80000000, 0, 1, 0, 0, ST_OVF));
        add_row(make_row(OP_SUB, 5, 7, 2, 3, 1, 3, 4, ST_OK));
        add_row(make_row(OP_MUL, 32'h80000000, 0, 1, 0, 1, 32'h80000000, 0, ST_OK));
        add_row(make_row(OP_MUL, 32'h80000000, 0, 32'hffffffff, 0, 1, 0, 0, ST_OVF));
        add_row(make_row(OP_MUL, 32'h10000, 0, 32'h10000, 0, 1, 0, 0, ST_OVF));
        add_row(make_row(OP_MUL, 32'h7fffffff, 32'h7fffffff, 1, 1, 0, 0, 0, ST_OK));
        add_row(make_row(OP_MUL, 32'h7fffffff, 32'h80000000, 1, 32'hffffffff,
                         0, 0, 0, ST_OK));
        add_row(make_row(OP_DIV, 5, 5, 0, 0, 1, 0, 0, ST_DIVZ));
        add_row(make_row(OP_DIV, 32'h80000000, 32'h7fffffff, 0, 0, 1, 0, 0, ST_DIVZ));
        add_row(make_row(OP_DIV, 7, 0, 2, 0, 1, 3, 0, ST_OK));
        add_row(make_row(OP_DIV, 32'hfffffff9, 0, 2, 0, 1, 32'hfffffffd, 0, ST_OK));
        add_row(make_row(OP_DIV, 1, 0, 32'h10000, 0, 1, 0, 0, ST_OVF));
        add_row(make_row(OP_DIV, 32'h7fffffff, 32'h7fffffff, 1, 1, 1, 0, 0, ST_OVF));
        add_row(make_row(OP_DIV, 32'h80000000, 0, 32'hffffffff, 0, 0, 0, 0, ST_OK));
        add_row(make_row(OP_DIV, 100, 37, 32'hfffffffd, 4, 0, 0, 0, ST_OK));
        add_row(make_row(OP_DIV, 0, 0, 46340, 0, 0, 0, 0, ST_OK));
        add_row(make_row(OP_DIV, 0, 0, 32767, 32767, 0, 0, 0, ST_OK));
        foreach (rows[i]) begin
            send_item(rows[i].op_item, rows[i].has_fixed, rows[i].fixed);
            if (i % 4 == 3) idle_gap();
        end

        // random part: long bursts and gapped stretches
        for (int i = 0; i < NumRandom; i++) begin
            mode   = $urandom_range(0, 9);
            x.op   = 2'($urandom_range(0, 3));
            x.a_real = pick_component(mode < 2 ? 0 : mode < 3 ? 1 : mode < 7 ? 2 : 3);
            x.a_imag = pick_component(mode < 2 ? 0 : mode < 3 ? 1 : mode < 7 ? 2 : 3);
            x.b_real = pick_component(mode < 2 ? 0 : mode < 4 ? 1 : mode < 7 ? 2 : 3);
            x.b_imag = pick_component(mode < 2 ? 0 : mode < 4 ? 1 : mode < 7 ? 2 : 3);
            if (x.op == OP_DIV && $urandom_range(0, 15) == 0) begin
                x.b_real = 0;
                x.b_imag = 0;
            end
            send_item(x, 1'b0, none);
            if ((i / 200) % 2 == 1) idle_gap();
        end
        op_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, with stretches of none
    initial begin
        int n;
        res_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = $urandom_range(0, 9);
            if ((cycle_cnt / 1500) % 3 == 0 || n < 6) begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b0;
                repeat (n < 9 ? $urandom_range(1, 3) : $urandom_range(5, 40))
                    @(posedge i_clk);
            end
        end
    end

    // Result checking
    always @(posedge i_clk) begin
        t_cia_out exp_r, got;
        int errs;
        errs = 0;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: real=%0d imag=%0d status=%0d",
                       got.res_real, got.res_imag, got.status);
                errs++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.res_real !== exp_r.res_real) begin
                    $error("res_real: expected %0d actual %0d", exp_r.res_real, got.res_real);
                    errs++;
                end
                if (got.res_imag !== exp_r.res_imag) begin
                    $error("res_imag: expected %0d actual %0d", exp_r.res_imag, got.res_imag);
                    errs++;
                end
                if (got.status !== exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status, got.status);
                    errs++;
                end
            end
        end
        if (errs != 0) n_errors <= n_errors + errs;
    end

    // End of run
    initial begin
        wait (stim_done);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("complex_int_alu_with_overflow_top test passed");
        end else begin
            $display("complex_int_alu_with_overflow_top test failed");
        end
        $finish;
    end
endmodule
